@@ hdl/two_level_message_ring_queue_assert.svh @@
// Assertion macros for the checker file of the message ring queue.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef TWO_LEVEL_MESSAGE_RING_QUEUE_ASSERT_SVH
`define TWO_LEVEL_MESSAGE_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, muted while reset is high
`define TLMRQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high
`define TLMRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tlmrq_pkg.sv @@
package tlmrq_pkg;

   // Default sizes
   localparam int NORMAL_DEPTH_DEF  = 128;
   localparam int PRIO_DEPTH_DEF    = 16;
   localparam int HANDLER_WIDTH_DEF = 8;

   // Fixed field widths on the ports
   localparam int HANDLER_PORT_W = 8;
   localparam int PARAM_W        = 32;
   localparam int DATA_W         = HANDLER_PORT_W + 2 * PARAM_W;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      MODE_POST_NORMAL = 2'd0,
      MODE_POST_PRIO   = 2'd1,
      MODE_PROCESS     = 2'd2
   } mode_type;

   // Response source codes carried on rsp_tuser
   typedef enum logic [1:0] {
      SRC_PRIO   = 2'd0,
      SRC_NORMAL = 2'd1,
      SRC_NONE   = 2'd2
   } src_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_PRIO,
      ST_POP_NORMAL,
      ST_NONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic    post_normal;
      logic    post_prio;
      logic    emit;
      src_type src;
      logic    last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic prio_empty;
      logic normal_empty;
      logic out_free;
   } status_type;

endpackage

@@ hdl/two_level_message_ring_queue.sv @@
// Two-level message ring queue: a normal and a priority circular queue of messages.
// Request channel (req_): tuser gives the kind (post normal, post priority, process);
// tdata carries handler, first and second parameter. Posts give no response; a
// priority post with a zero buffer or a length that is not positive is dropped.
// A full queue overwrites its oldest message, so each holds depth-1 messages.
// Response channel (rsp_): one response per popped message, priority first, then
// normal; a single "none" response when both are empty; tlast marks the final one.
// Timing: a process request is taken into the state register, and its first response
// then goes through the output register onto rsp_tvalid; a stalled receiver can hold
// it back in between. The controller steps through the pops one per cycle, while the
// output register is free, into a single output register, and req_tready is low
// until the last response of a process request is loaded.
// Posts are still taken while a finished response waits in the output register.
// Reset empties both queues (pointers to zero) and clears the output valid flag;
// the stores themselves are not cleared. A stalled receiver holds the response
// and its tdata/tuser/tlast steady until rsp_tready.
module two_level_message_ring_queue
   import tlmrq_pkg::*;
#(
   parameter int NORMAL_DEPTH  = NORMAL_DEPTH_DEF,
   parameter int PRIO_DEPTH    = PRIO_DEPTH_DEF,
   parameter int HANDLER_WIDTH = HANDLER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // handler[7:0], first_param[39:8], second_param[71:40]
   input  logic [1:0]        req_tuser,   // mode[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // out_handler[7:0], out_first[39:8], out_second[71:40]
   output logic [1:0]        rsp_tuser,   // source[1:0]
   output logic              rsp_tlast
);

   cmd_type    cmd;
   status_type sts;

   tlmrq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   tlmrq_dp #(
      .NORMAL_DEPTH  (NORMAL_DEPTH),
      .PRIO_DEPTH    (PRIO_DEPTH),
      .HANDLER_WIDTH (HANDLER_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ hdl/tlmrq_ram.sv @@
module tlmrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tlmrq_ctrl.sv @@
module tlmrq_ctrl
   import tlmrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   mode_type  mode;

   assign mode = mode_type'(req_tuser);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.src    = SRC_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (mode)
                  MODE_POST_NORMAL: cmd.post_normal = 1'b1;
                  MODE_POST_PRIO:   cmd.post_prio = 1'b1;
                  MODE_PROCESS: begin
                     if (!sts.prio_empty) begin
                        state_in = ST_POP_PRIO;
                     end else if (!sts.normal_empty) begin
                        state_in = ST_POP_NORMAL;
                     end else begin
                        state_in = ST_NONE;
                     end
                  end
                  default: ;  // unused kind: dropped
               endcase
            end
         end
         ST_POP_PRIO: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_PRIO;
               cmd.last = sts.normal_empty;
               state_in = sts.normal_empty ? ST_IDLE : ST_POP_NORMAL;
            end
         end
         ST_POP_NORMAL: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_NORMAL;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_NONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_NONE;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hdl/tlmrq_dp.sv @@
module tlmrq_dp
   import tlmrq_pkg::*;
#(
   parameter int NORMAL_DEPTH  = NORMAL_DEPTH_DEF,
   parameter int PRIO_DEPTH    = PRIO_DEPTH_DEF,
   parameter int HANDLER_WIDTH = HANDLER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [DATA_W-1:0] req_tdata,
   output status_type        sts,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int N_AW    = $clog2(NORMAL_DEPTH);
   localparam int P_AW    = $clog2(PRIO_DEPTH);
   localparam int ENTRY_W = HANDLER_WIDTH + 2 * PARAM_W;

   logic [N_AW-1:0] norm_wr_ff, norm_wr_in, norm_rd_ff, norm_rd_in;
   logic [N_AW-1:0] norm_wr_inc, norm_rd_inc;
   logic [P_AW-1:0] prio_wr_ff, prio_wr_in, prio_rd_ff, prio_rd_in;
   logic [P_AW-1:0] prio_wr_inc, prio_rd_inc;

   logic [HANDLER_PORT_W-1:0] in_handler;
   logic [PARAM_W-1:0]        in_first, in_second;
   logic [HANDLER_WIDTH-1:0]  wr_handler;
   logic [ENTRY_W-1:0]        wr_entry, norm_entry, prio_entry;
   logic                      prio_ok;

   logic [HANDLER_PORT_W-1:0] norm_handler, prio_handler;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   src_type           rsp_src_ff, rsp_src_in;
   logic              rsp_last_ff, rsp_last_in;

   // Request fields
   assign in_handler = req_tdata[HANDLER_PORT_W-1:0];
   assign in_first   = req_tdata[HANDLER_PORT_W +: PARAM_W];
   assign in_second  = req_tdata[HANDLER_PORT_W+PARAM_W +: PARAM_W];

   // Handler width conversion between the port and the stores
   generate
      if (HANDLER_WIDTH > HANDLER_PORT_W) begin : g_wide
         assign wr_handler   = {{(HANDLER_WIDTH-HANDLER_PORT_W){1'b0}}, in_handler};
         assign norm_handler = norm_entry[HANDLER_PORT_W-1:0];
         assign prio_handler = prio_entry[HANDLER_PORT_W-1:0];
      end else if (HANDLER_WIDTH == HANDLER_PORT_W) begin : g_same
         assign wr_handler   = in_handler;
         assign norm_handler = norm_entry[HANDLER_WIDTH-1:0];
         assign prio_handler = prio_entry[HANDLER_WIDTH-1:0];
      end else begin : g_narrow
         assign wr_handler   = in_handler[HANDLER_WIDTH-1:0];
         assign norm_handler = {{(HANDLER_PORT_W-HANDLER_WIDTH){1'b0}},
                                norm_entry[HANDLER_WIDTH-1:0]};
         assign prio_handler = {{(HANDLER_PORT_W-HANDLER_WIDTH){1'b0}},
                                prio_entry[HANDLER_WIDTH-1:0]};
      end
   endgenerate

   assign wr_entry = {in_second, in_first, wr_handler};

   // Priority post needs a nonzero buffer and a positive length
   assign prio_ok = (in_first != '0) && (in_second != '0) && !in_second[PARAM_W-1];

   // Wrapping pointer increments
   assign norm_wr_inc = (norm_wr_ff == N_AW'(NORMAL_DEPTH - 1)) ? '0 : norm_wr_ff + 1'b1;
   assign norm_rd_inc = (norm_rd_ff == N_AW'(NORMAL_DEPTH - 1)) ? '0 : norm_rd_ff + 1'b1;
   assign prio_wr_inc = (prio_wr_ff == P_AW'(PRIO_DEPTH - 1)) ? '0 : prio_wr_ff + 1'b1;
   assign prio_rd_inc = (prio_rd_ff == P_AW'(PRIO_DEPTH - 1)) ? '0 : prio_rd_ff + 1'b1;

   // Message stores, read continuously at the read pointers
   tlmrq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NORMAL_DEPTH)
   ) u_norm_ram (
      .clock   (clock),
      .wr_en   (cmd.post_normal),
      .wr_addr (norm_wr_ff),
      .wr_data (wr_entry),
      .rd_addr (norm_rd_ff),
      .rd_data (norm_entry)
   );

   tlmrq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PRIO_DEPTH)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (cmd.post_prio && prio_ok),
      .wr_addr (prio_wr_ff),
      .wr_data (wr_entry),
      .rd_addr (prio_rd_ff),
      .rd_data (prio_entry)
   );

   // Pointer updates: a post that catches the read pointer drops the oldest
   always_comb begin
      norm_wr_in = norm_wr_ff;
      norm_rd_in = norm_rd_ff;
      prio_wr_in = prio_wr_ff;
      prio_rd_in = prio_rd_ff;
      if (cmd.post_normal) begin
         norm_wr_in = norm_wr_inc;
         if (norm_wr_inc == norm_rd_ff) begin
            norm_rd_in = norm_rd_inc;
         end
      end
      if (cmd.post_prio && prio_ok) begin
         prio_wr_in = prio_wr_inc;
         if (prio_wr_inc == prio_rd_ff) begin
            prio_rd_in = prio_rd_inc;
         end
      end
      if (cmd.emit && (cmd.src == SRC_PRIO)) begin
         prio_rd_in = prio_rd_inc;
      end
      if (cmd.emit && (cmd.src == SRC_NORMAL)) begin
         norm_rd_in = norm_rd_inc;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_src_in   = cmd.src;
         rsp_last_in  = cmd.last;
         case (cmd.src)
            SRC_PRIO:   rsp_data_in = {prio_entry[ENTRY_W-1:HANDLER_WIDTH], prio_handler};
            SRC_NORMAL: rsp_data_in = {norm_entry[ENTRY_W-1:HANDLER_WIDTH], norm_handler};
            default:    rsp_data_in = '0;
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_wr_ff   <= '0;
         norm_rd_ff   <= '0;
         prio_wr_ff   <= '0;
         prio_rd_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         norm_wr_ff   <= norm_wr_in;
         norm_rd_ff   <= norm_rd_in;
         prio_wr_ff   <= prio_wr_in;
         prio_rd_ff   <= prio_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Status back to the controller
   assign sts.prio_empty   = (prio_rd_ff == prio_wr_ff);
   assign sts.normal_empty = (norm_rd_ff == norm_wr_ff);
   assign sts.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_src_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hdl/tlmrq_checker.sv @@
`include "two_level_message_ring_queue_assert.svh"

module tlmrq_checker
   import tlmrq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [1:0]        req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [1:0]        rsp_tuser,
   input logic              rsp_tlast
);

   logic process_fire;
   logic rsp_stall;
   logic none_rsp;
   logic normal_rsp;

   assign process_fire = req_tvalid && req_tready && (req_tuser == MODE_PROCESS);
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign none_rsp     = rsp_tvalid && (rsp_tuser == SRC_NONE);
   assign normal_rsp   = rsp_tvalid && (rsp_tuser == SRC_NORMAL);

   // A stalled response keeps its contents
   `TLMRQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}), "response changed while stalled")

   // Nothing pending: zero payload, final response
   `TLMRQ_ASSERT_NOW(a_none_zero, none_rsp, (rsp_tdata == '0) && rsp_tlast, "none response not empty or not last")

   // A normal-queue pop is always the final response of its request
   `TLMRQ_ASSERT_NOW(a_normal_last, normal_rsp, rsp_tlast, "normal response without tlast")

   // A process request blocks the request channel in the cycle after it is accepted
   `TLMRQ_ASSERT_NEXT(a_process_busy, process_fire, !req_tready, "request taken right after a process request")

endmodule

bind two_level_message_ring_queue tlmrq_checker u_checker (.*);

@@ tb/two_level_message_ring_queue_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the message ring queue. It predicts the responses of
// every accepted request and compares each accepted response with the oldest one.
module two_level_message_ring_queue_checker
   import tlmrq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,
   input  logic [1:0]        rsp_tuser,
   input  logic              rsp_tlast,
   output int                failures,
   output int                outstanding
);

   localparam int NORMAL_PTR_W = $clog2(NORMAL_DEPTH_DEF);
   localparam int PRIO_PTR_W   = $clog2(PRIO_DEPTH_DEF);

   // Same layout as tdata: handler in the low byte
   typedef struct packed {
      logic [PARAM_W-1:0]        second;
      logic [PARAM_W-1:0]        first;
      logic [HANDLER_PORT_W-1:0] handler;
   } message_type;

   typedef struct packed {
      src_type     source;
      message_type msg;
      logic        last;
   } response_type;

   // Shadow copy of both rings
   message_type             normal_ring [NORMAL_DEPTH_DEF];
   message_type             prio_ring [PRIO_DEPTH_DEF];
   logic [NORMAL_PTR_W-1:0] normal_rd, normal_wr;
   logic [PRIO_PTR_W-1:0]   prio_rd, prio_wr;
   response_type            due_responses [$];

   function automatic logic [NORMAL_PTR_W-1:0] next_normal(input logic [NORMAL_PTR_W-1:0] p);
      return (p == NORMAL_DEPTH_DEF - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PRIO_PTR_W-1:0] next_prio(input logic [PRIO_PTR_W-1:0] p);
      return (p == PRIO_DEPTH_DEF - 1) ? '0 : p + 1'b1;
   endfunction

   // Applies one request to the shadow rings and queues the responses it causes
   function automatic void predict_request(input logic [1:0] mode, input message_type msg);
      response_type rsp;
      logic         normal_waiting;
      logic         popped;
      popped = 1'b0;
      case (mode)
         MODE_POST_NORMAL: begin
            normal_ring[normal_wr] = msg;
            normal_wr = next_normal(normal_wr);
            // full ring overwrites the oldest message
            if (normal_wr == normal_rd)
               normal_rd = next_normal(normal_rd);
         end
         MODE_POST_PRIO: begin
            // zero buffer or non-positive length is dropped
            if (msg.first != '0 && $signed(msg.second) > 0) begin
               prio_ring[prio_wr] = msg;
               prio_wr = next_prio(prio_wr);
               if (prio_wr == prio_rd)
                  prio_rd = next_prio(prio_rd);
            end
         end
         MODE_PROCESS: begin
            normal_waiting = (normal_rd != normal_wr);
            if (prio_rd != prio_wr) begin
               rsp.source = SRC_PRIO;
               rsp.msg    = prio_ring[prio_rd];
               rsp.last   = !normal_waiting;
               due_responses.push_back(rsp);
               prio_rd = next_prio(prio_rd);
               popped  = 1'b1;
            end
            if (normal_waiting) begin
               rsp.source = SRC_NORMAL;
               rsp.msg    = normal_ring[normal_rd];
               rsp.last   = 1'b1;
               due_responses.push_back(rsp);
               normal_rd = next_normal(normal_rd);
               popped    = 1'b1;
            end
            if (!popped) begin
               rsp.source = SRC_NONE;
               rsp.msg    = '0;
               rsp.last   = 1'b1;
               due_responses.push_back(rsp);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [PARAM_W-1:0] want,
                                       input logic [PARAM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // Requests are predicted before responses of the same edge are checked
   always @(posedge clock) begin
      response_type want;
      message_type  got;
      if (reset) begin
         normal_rd = '0;
         normal_wr = '0;
         prio_rd   = '0;
         prio_wr   = '0;
         failures  = 0;
         due_responses.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_request(req_tuser, message_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (due_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, got source %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = due_responses.pop_front();
               got  = message_type'(rsp_tdata);
               check_field("source", want.source, rsp_tuser);
               check_field("handler", want.msg.handler, got.handler);
               check_field("first", want.msg.first, got.first);
               check_field("second", want.msg.second, got.second);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
      outstanding <= due_responses.size();
   end

endmodule

@@ tb/two_level_message_ring_queue_tb.sv @@
`timescale 1ns / 100ps

module two_level_message_ring_queue_tb;
   import tlmrq_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         ITEM_TARGET = 1450;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [1:0]        req_tuser = MODE_POST_NORMAL;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;
   int                failures;
   int                outstanding;
   int                sent = 0;
   bit                calm = 1'b0;

   two_level_message_ring_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   two_level_message_ring_queue_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none while calm
   function automatic int idle_gap();
      int pick;
      if (calm)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PARAM_W-1:0] rand_param();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] rand_handler();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // One request; returns at the edge where it was accepted
   task automatic send_request(input logic [1:0] mode, input logic [7:0] handler,
                               input logic [PARAM_W-1:0] first,
                               input logic [PARAM_W-1:0] second);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {second, first, handler};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // dropped priority posts and the unused kind do nothing
      if (mode == MODE_POST_NORMAL || mode == MODE_PROCESS ||
          (mode == MODE_POST_PRIO && first != '0 && $signed(second) > 0))
         sent++;
   endtask

   task automatic post_normal(input logic [7:0] handler, input logic [PARAM_W-1:0] first,
                              input logic [PARAM_W-1:0] second);
      send_request(MODE_POST_NORMAL, handler, first, second);
   endtask

   task automatic post_prio(input logic [7:0] handler, input logic [PARAM_W-1:0] first,
                            input logic [PARAM_W-1:0] second);
      send_request(MODE_POST_PRIO, handler, first, second);
   endtask

   task automatic process_next();
      send_request(MODE_PROCESS, rand_handler(), rand_param(), rand_param());
   endtask

   task automatic post_prio_good();
      logic [PARAM_W-1:0] first;
      logic [PARAM_W-1:0] second;
      first = rand_param();
      while (first == '0) first = rand_param();
      case ($urandom_range(0, 3))
         0: second = 32'h7FFF_FFFF;
         1: second = 32'd1;
         default: second = $urandom_range(32'h7FFF_FFFF, 1);
      endcase
      post_prio(rand_handler(), first, second);
   endtask

   task automatic post_prio_bad();
      if ($urandom_range(0, 1))
         post_prio(rand_handler(), '0, rand_param());
      else if ($urandom_range(0, 1))
         post_prio(rand_handler(), rand_param(), '0);
      else
         post_prio(rand_handler(), rand_param(), {1'b1, 31'($urandom)});
   endtask

   // One request of random kind, weighted toward traffic that reaches both rings
   task automatic send_mixed();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)
         post_normal(rand_handler(), rand_param(), rand_param());
      else if (pick < 60)
         post_prio_good();
      else if (pick < 66)
         post_prio_bad();
      else if (pick < 98)
         process_next();
      else
         send_request(MODE_UNUSED, rand_handler(), rand_param(), rand_param());
   endtask

   // Hold off until every expected response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Receiver: runs of ready broken by random stalls
   initial begin
      int stall;
      forever begin
         stall = idle_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int  pick;
      int  burst;
      bit  first_burst;
      bit  paused;
      first_burst = 1'b1;
      paused      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // both rings empty
      process_next();
      post_normal(8'h00, 32'h8000_0000, 32'h7FFF_FFFF);
      post_normal(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
      post_prio(8'h80, 32'd1, 32'd1);
      // dropped priority posts: zero buffer, zero and negative lengths
      post_prio(8'h11, 32'd0, 32'd5);
      post_prio(8'h22, 32'd7, 32'd0);
      post_prio(8'h33, 32'd7, 32'hFFFF_FFFF);
      post_prio(8'h44, 32'd7, 32'h8000_0000);
      post_prio(8'hFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // priority then normal twice, then nothing pending
      process_next();
      process_next();
      process_next();
      // priority only, handler zero
      post_prio(8'h00, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      process_next();
      // normal only, all zero
      post_normal(8'h00, 32'd0, 32'd0);
      process_next();
      process_next();
      drain();

      // random bursts: overfill either ring, drain, or mix
      while (sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 7) == 0);
         pick = $urandom_range(0, 99);
         if (first_burst || pick < 3) begin
            burst = $urandom_range(130, 140);
            repeat (burst) post_normal(rand_handler(), rand_param(), rand_param());
         end else if (pick < 10) begin
            burst = $urandom_range(17, 22);
            repeat (burst) post_prio_good();
         end else if (pick < 22) begin
            burst = $urandom_range(5, 30);
            repeat (burst) process_next();
         end else begin
            burst = $urandom_range(1, 20);
            repeat (burst) send_mixed();
         end
         first_burst = 1'b0;
         if (!paused && sent > ITEM_TARGET / 2) begin
            drain();
            paused = 1'b1;
         end
      end

      calm = 1'b0;
      drain();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
